[rtl/core/bpl_pkg.sv]
// Package with the shared types and constants of the program listing decoder.
`timescale 1ns / 1ps

package bpl_pkg;

  localparam int NUM_DIGITS  = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] END_MARK   = 8'hff;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_START = 2'd1,
    PH_LOW   = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_CHAR = 2'd1,
    JOB_NUM  = 2'd2
  } job_kind_t;

  // One classified request: characters to produce, then an optional status item.
  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] val;
    logic        status;
    logic        bad;
  } job_t;

endpackage

[rtl/core/bpl_if.sv]
// Valid/ready channel interfaces for the program listing decoder.
`timescale 1ns / 1ps

interface bpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface bpl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_end;
  logic       program_done;
  logic       bad_end;

  modport source (output valid, out_char, char_valid, run_end, program_done, bad_end,
                  input ready);
  modport sink   (input valid, out_char, char_valid, run_end, program_done, bad_end,
                  output ready);
endinterface

[rtl/core/bpl_front.sv]
// Front end: accepts image bytes, tracks the line layout and classifies each byte.
`timescale 1ns / 1ps

module bpl_front import bpl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  bpl_in_if.sink in_ch,
  input  logic   q_full,
  output logic   push,
  output job_t   job
);

  phase_t      phase_r, phase_nxt;
  logic        first_break_r, first_break_nxt;
  logic [7:0]  number_high_r, number_high_nxt;
  logic        accept;
  logic        ended;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign ended       = (phase_r == PH_START) && (in_ch.in_byte == END_MARK);

  // Next state.
  always_comb begin
    phase_nxt       = phase_r;
    first_break_nxt = first_break_r;
    number_high_nxt = number_high_r;
    unique case (phase_r)
      PH_START: begin
        if (ended) begin
          phase_nxt = PH_DONE;
        end else begin
          number_high_nxt = in_ch.in_byte;
          phase_nxt       = PH_LOW;
        end
      end
      PH_LOW: begin
        phase_nxt = PH_TEXT;
      end
      PH_TEXT: begin
        if (in_ch.in_byte == CHAR_CR) begin
          first_break_nxt = 1'b0;
          phase_nxt       = PH_START;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_TEXT;
      end
    endcase
    // A last byte always sends the decoder back to its reset state, the text phase.
    if (in_ch.in_last) begin
      phase_nxt       = PH_TEXT;
      first_break_nxt = 1'b1;
      number_high_nxt = '0;
    end
  end

  // Job for the back end.
  always_comb begin
    job.kind   = JOB_NONE;
    job.val    = {8'h00, in_ch.in_byte};
    job.status = ended || in_ch.in_last;
    job.bad    = in_ch.in_last && !ended && (phase_r != PH_DONE);
    unique case (phase_r)
      PH_START: begin
        job.kind = JOB_NONE;
      end
      PH_LOW: begin
        job.kind = JOB_NUM;
        job.val  = {number_high_r, in_ch.in_byte};
      end
      PH_TEXT: begin
        if (in_ch.in_byte != CHAR_CR || !first_break_r) begin
          job.kind = JOB_CHAR;
        end
      end
      PH_DONE: begin
        job.kind = JOB_NONE;
      end
      default: begin
        job.kind = JOB_NONE;
      end
    endcase
    push = accept && ((job.kind != JOB_NONE) || job.status);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TEXT;
      first_break_r <= 1'b1;
      number_high_r <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      first_break_r <= first_break_nxt;
      number_high_r <= number_high_nxt;
    end
  end

endmodule

[rtl/core/bpl_queue.sv]
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module bpl_queue import bpl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from an empty queue");

endmodule

[rtl/core/bpl_back.sv]
// Back end: expands queued jobs into listing characters and status items.
`timescale 1ns / 1ps

module bpl_back import bpl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  job_t        head,
  output logic        pop,
  bpl_out_if.source   out_ch
);

  logic [2:0]  cnt_r;
  logic [15:0] rem_r;
  logic        nz_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        char_valid_r;
  logic        run_end_r;
  logic        program_done_r;
  logic        bad_end_r;

  logic [2:0]  nchars;
  logic        is_char;
  logic        final_item;
  logic        advance;
  logic [15:0] v;
  logic [16:0] pw;
  logic [16:0] thr [10];
  logic [3:0]  d;
  logic [15:0] rem;
  logic        nz;
  logic        blank;
  logic [7:0]  ch;

  // Place value of the digit produced at step idx, most significant first.
  function automatic logic [16:0] pow10(input logic [2:0] idx);
    logic [16:0] r;
    case (idx)
      3'd0:    r = 17'd10000;
      3'd1:    r = 17'd1000;
      3'd2:    r = 17'd100;
      3'd3:    r = 17'd10;
      default: r = 17'd1;
    endcase
    return r;
  endfunction

  always_comb begin
    case (head.kind)
      JOB_CHAR: nchars = 3'd1;
      JOB_NUM:  nchars = 3'(NUM_DIGITS);
      default:  nchars = 3'd0;
    endcase
    is_char    = cnt_r < nchars;
    final_item = is_char ? ((cnt_r == nchars - 3'd1) && !head.status) : 1'b1;
  end

  // One decimal digit per step: compare against the nine multiples of the place value.
  always_comb begin
    v  = (cnt_r == '0) ? head.val : rem_r;
    pw = pow10(cnt_r);
    d  = '0;
    for (int i = 0; i < 10; i++) begin
      thr[i] = 17'(pw * 17'(i));
    end
    for (int i = 1; i < 10; i++) begin
      if ({1'b0, v} >= thr[i]) begin
        d = 4'(i);
      end
    end
    rem   = v - thr[d][15:0];
    nz    = (cnt_r != '0) && nz_r;
    blank = (d == '0) && !nz && (cnt_r != 3'(NUM_DIGITS - 1));
    if (head.kind == JOB_NUM) begin
      ch = blank ? CHAR_SPACE : (CHAR_ZERO + {4'b0000, d});
    end else begin
      ch = head.val[7:0];
    end
  end

  assign advance = head_valid && (!out_valid_r || out_ch.ready);
  assign pop     = advance && final_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        cnt_r       <= final_item ? 3'd0 : cnt_r + 3'd1;
        nz_r        <= nz || (d != '0);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_r          <= rem;
      out_char_r     <= is_char ? ch : 8'h00;
      char_valid_r   <= is_char;
      run_end_r      <= final_item;
      program_done_r <= !is_char;
      bad_end_r      <= !is_char && head.bad;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_char     = out_char_r;
  assign out_ch.char_valid   = char_valid_r;
  assign out_ch.run_end      = run_end_r;
  assign out_ch.program_done = program_done_r;
  assign out_ch.bad_end      = bad_end_r;

  a_status_has_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && program_done_r |-> !char_valid_r && run_end_r)
    else $error("status item carries a character or is not final");

  a_pop_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> cnt_r == '0)
    else $error("step counter not cleared after a job ended");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(NUM_DIGITS))
    else $error("step counter beyond the longest job");

endmodule

[rtl/core/basic_program_listing_decoder.sv]
// Top level of the program listing decoder: front end, job queue and back end.
// Path: an accepted request is written into the job queue, and the back end then registers
// its first result in the output register before the result can be taken.
// Throughput: one input byte and one result per cycle while the queue is not full and the
// output is ready; a line-number low byte expands to five digits while the four-entry queue fills.
// Reset: synchronous, active low; the decoder starts in text phase before any line.
`timescale 1ns / 1ps

module basic_program_listing_decoder import bpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bpl_in_if.sink    in_ch,
  bpl_out_if.source out_ch
);

  logic push;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t job;
  job_t head;

  bpl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (job)
  );

  bpl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .job_in     (job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bpl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
